### rtl/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared widths, limits, register indexes, the cordic arctangent table and the
// types passed between the tilt angle modules.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int IN_W       = 16;
  localparam int OFF_W      = 16;
  localparam int GAIN_W     = 17;
  localparam int OUT_W      = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_OFFSET   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = CFG_IDX_W'(1);

  localparam logic signed [OFF_W-1:0] OFFSET_RESET = OFF_W'(0);
  localparam logic [GAIN_W-1:0]       GAIN_RESET   = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0]       GAIN_ONE     = GAIN_W'(65536);

  localparam int SQ_W        = 2 * IN_W - 1;
  localparam int SUMSQ_W     = 2 * IN_W;
  localparam int RAD_FRAC_W  = 16;
  localparam int RAD_W       = SUMSQ_W + RAD_FRAC_W;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 2;
  localparam int SQRT_CYCLES = ROOT_W / 2;
  localparam int SQRT_CNT_W  = $clog2(SQRT_CYCLES);

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN          = 24;
  localparam int ATAN_W            = 23;
  localparam int SHIFT_W           = $clog2(ATAN_LEN);
  localparam int XY_W              = 27;
  localparam int Z_W               = 25;
  localparam int Y_SHIFT           = 8;

  localparam int ANG_W        = 16;
  localparam int TGT_W        = 17;
  localparam int ACC_W        = 34;
  localparam int ACC_FRAC_W   = 16;
  localparam int TILT_LIMIT   = 23040;
  localparam int TARGET_LIMIT = 46080;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666,   23'd29335,   23'd14668,  23'd7334,   23'd3667,   23'd1833,
    23'd917,     23'd458,     23'd229,    23'd115,    23'd57,     23'd29,
    23'd14,      23'd7,       23'd4,      23'd2,      23'd1,      23'd0
  };

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } atl_cordic_t;

  typedef struct packed {
    logic idle;
    logic done;
  } atl_filt_stat_t;

endpackage

### rtl/atl_isqrt.sv
// ----------------------------------------------------------------------------
// atl_isqrt
// Iterative integer square root of sumsq * 65536, two root bits per cycle.
// ----------------------------------------------------------------------------
module atl_isqrt import atl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUMSQ_W-1:0] sumsq,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  function automatic sq_state_t sq_step(input sq_state_t s, input logic [1:0] pair);
    logic [REM_W+1:0] wide;
    logic [REM_W+1:0] trial;
    sq_state_t        r;
    wide  = {s.rem, pair};
    trial = {2'b00, s.root, 2'b01};
    if (wide >= trial) begin
      r.rem  = REM_W'(wide - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = wide[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic                  busy_r;
  logic                  done_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  sq_state_t             step1;
  sq_state_t             step2;

  always_comb begin
    step1 = sq_step({rem_r, root_r}, rad_r[RAD_W-1 -: 2]);
    step2 = sq_step(step1, rad_r[RAD_W-3 -: 2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SQRT_CNT_W'(1);
        if (cnt_r == SQRT_CNT_W'(SQRT_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= {sumsq, {RAD_FRAC_W{1'b0}}};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 4;
      rem_r  <= step2.rem;
      root_r <= step2.root;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/atl_cordic_cell.sv
// ----------------------------------------------------------------------------
// atl_cordic_cell
// One vectoring cordic micro-rotation, registered, handed to the next cell.
// ----------------------------------------------------------------------------
module atl_cordic_cell import atl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SHIFT_W-1:0] shamt,
  input  logic [ATAN_W-1:0]  atan,
  input  atl_cordic_t        cell_in,
  output atl_cordic_t        cell_out
);

  logic                   valid_r;
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic signed [XY_W-1:0] x_in, y_in, x_sh, y_sh, x_nxt, y_nxt;
  logic signed [Z_W-1:0]  z_in, atan_s, z_nxt;

  always_comb begin
    x_in   = cell_in.x;
    y_in   = cell_in.y;
    z_in   = cell_in.z;
    atan_s = {{(Z_W-ATAN_W){1'b0}}, atan};
    x_sh   = x_in >>> shamt;
    y_sh   = y_in >>> shamt;
    if (y_in[XY_W-1]) begin
      x_nxt = x_in - y_sh;
      y_nxt = y_in + x_sh;
      z_nxt = z_in - atan_s;
    end else begin
      x_nxt = x_in + y_sh;
      y_nxt = y_in - x_sh;
      z_nxt = z_in + atan_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_in.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    cell_out.valid = valid_r;
    cell_out.x     = x_r;
    cell_out.y     = y_r;
    cell_out.z     = z_r;
  end

endmodule

### rtl/atl_filter.sv
// ----------------------------------------------------------------------------
// atl_filter
// Rounds and clamps the cordic angle, applies the offset, runs the low-pass
// update on the accumulator and holds the result in the output register.
// ----------------------------------------------------------------------------
module atl_filter import atl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    z_valid,
  input  logic signed [Z_W-1:0]   z_in,
  input  logic                    zero_vec,
  input  logic signed [OFF_W-1:0] angle_offset,
  input  logic [GAIN_W-1:0]       smoothing_gain,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_filtered_angle,
  output atl_filt_stat_t          stat
);

  localparam int DIFF_W = ACC_W + 1;
  localparam int DH_W   = DIFF_W - GAIN_W;
  localparam int PH_W   = 2 * (GAIN_W + 1);
  localparam int PL_W   = 2 * GAIN_W;
  localparam int SUM_W  = PH_W + GAIN_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TARGET = 7'b0000010,
    S_DIFF   = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_SUM    = 7'b0010000,
    S_ACC    = 7'b0100000,
    S_OUT    = 7'b1000000
  } filt_state_t;

  filt_state_t state_r, state_nxt;

  logic signed [ANG_W-1:0]  ang_r, ang_nxt;
  logic signed [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic signed [PH_W-1:0]   ph_r, ph_nxt;
  logic [PL_W-1:0]          pl_r, pl_nxt;
  logic signed [ACC_W-1:0]  delta_r, delta_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic signed [Z_W:0]      zsum;
  logic signed [Z_W-8:0]    zsh;
  logic signed [TGT_W-1:0]  tdiff;
  logic [GAIN_W-1:0]        gain_sat;
  logic signed [GAIN_W:0]   gain_s;
  logic signed [DH_W-1:0]   diff_hi;
  logic [GAIN_W-1:0]        diff_lo;
  logic signed [SUM_W-1:0]  psum;
  logic signed [ACC_W:0]    ores;
  logic                     out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (z_valid) state_nxt = S_TARGET;
      S_TARGET: state_nxt = S_DIFF;
      S_DIFF:   state_nxt = S_MUL;
      S_MUL:    state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ACC;
      S_ACC:    state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // angle round half up and clamp
  always_comb begin
    zsum = {z_in[Z_W-1], z_in} + (Z_W+1)'(128);
    zsh  = zsum[Z_W:8];
    if (zero_vec) begin
      ang_nxt = '0;
    end else if (zsh > TILT_LIMIT) begin
      ang_nxt = ANG_W'(TILT_LIMIT);
    end else if (zsh < -TILT_LIMIT) begin
      ang_nxt = ANG_W'(-TILT_LIMIT);
    end else begin
      ang_nxt = zsh[ANG_W-1:0];
    end
  end

  // offset and target clamp
  always_comb begin
    tdiff = {ang_r[ANG_W-1], ang_r} - {angle_offset[OFF_W-1], angle_offset};
    if (tdiff > TARGET_LIMIT) begin
      tgt_nxt = TGT_W'(TARGET_LIMIT);
    end else if (tdiff < -TARGET_LIMIT) begin
      tgt_nxt = TGT_W'(-TARGET_LIMIT);
    end else begin
      tgt_nxt = tdiff;
    end
  end

  always_comb begin
    diff_nxt = {{(DIFF_W-TGT_W-ACC_FRAC_W){tgt_r[TGT_W-1]}}, tgt_r, {ACC_FRAC_W{1'b0}}}
               - {acc_r[ACC_W-1], acc_r};
    gain_sat = (smoothing_gain[GAIN_W-1] && (|smoothing_gain[GAIN_W-2:0])) ?
               GAIN_ONE : smoothing_gain;
    gain_s   = {1'b0, gain_sat};
    diff_hi  = diff_r[DIFF_W-1:GAIN_W];
    diff_lo  = diff_r[GAIN_W-1:0];
    ph_nxt   = gain_s * diff_hi;
    pl_nxt   = gain_sat * diff_lo;
    psum     = $signed({ph_r, {GAIN_W{1'b0}}}) + $signed({{(SUM_W-PL_W){1'b0}}, pl_r});
    delta_nxt = psum[ACC_W+ACC_FRAC_W-1:ACC_FRAC_W];
    ores     = {acc_r[ACC_W-1], acc_r} + (ACC_W+1)'(32768);
    out_data_nxt = ores[ACC_FRAC_W+OUT_W-1:ACC_FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ACC) begin
        acc_r <= acc_r + delta_r;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && z_valid) begin
      ang_r <= ang_nxt;
    end
    if (state_r == S_TARGET) begin
      tgt_r <= tgt_nxt;
    end
    if (state_r == S_DIFF) begin
      diff_r <= diff_nxt;
    end
    if (state_r == S_MUL) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (state_r == S_SUM) begin
      delta_r <= delta_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_data_r;
  assign stat.idle          = (state_r == S_IDLE);
  assign stat.done          = (state_r == S_OUT) && out_free;

endmodule

### rtl/accel_tilt_angle_lowpass.sv
// ----------------------------------------------------------------------------
// accel_tilt_angle_lowpass
// One input transaction is in flight at a time: in_stall stays high from
// acceptance through the start register, the square root, the 16 cordic
// cells and the 7-step filter sequence. A result waiting in the output
// register does not block the next input transaction.
// Synchronous active-low reset clears control, the filter accumulator, the
// offset (0) and the gain (3277).
// ----------------------------------------------------------------------------
module accel_tilt_angle_lowpass import atl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [IN_W-1:0]  in_accel_x,
  input  logic signed [IN_W-1:0]  in_accel_y,
  input  logic signed [IN_W-1:0]  in_accel_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_filtered_angle,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int LAST = CORDIC_ITERATIONS - 1;

  logic                    busy_r;
  logic                    start_r;
  logic                    zero_r;
  logic signed [IN_W-1:0]  x_r;
  logic [SQ_W-1:0]         sq_y_r, sq_z_r, sq_y_nxt, sq_z_nxt;
  logic signed [OFF_W-1:0] offset_r;
  logic [GAIN_W-1:0]       gain_r;

  logic                    accept;
  logic signed [SUMSQ_W-1:0] ay, az, py, pz;
  logic [SUMSQ_W-1:0]      sumsq;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       sqrt_root;
  logic signed [XY_W-1:0]  x_ext;
  atl_cordic_t             cell_head;
  atl_cordic_t             cell_in  [CORDIC_ITERATIONS];
  atl_cordic_t             cell_out [CORDIC_ITERATIONS];
  logic [CORDIC_ITERATIONS-1:0] cell_v;
  atl_filt_stat_t          filt_stat;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;

  always_comb begin
    ay       = in_accel_y;
    az       = in_accel_z;
    py       = ay * ay;
    pz       = az * az;
    sq_y_nxt = py[SQ_W-1:0];
    sq_z_nxt = pz[SQ_W-1:0];
    sumsq    = SUMSQ_W'(sq_y_r) + SUMSQ_W'(sq_z_r);
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_OFFSET:   offset_r <= cfg_data[OFF_W-1:0];
        REG_SMOOTHING_GAIN: gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      start_r <= 1'b0;
    end else begin
      start_r <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (filt_stat.done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_accel_x;
      sq_y_r <= sq_y_nxt;
      sq_z_r <= sq_z_nxt;
      zero_r <= (in_accel_x == '0) && (in_accel_y == '0) && (in_accel_z == '0);
    end
  end

  atl_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .sumsq (sumsq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    x_ext           = x_r;
    cell_head.valid = sqrt_done;
    cell_head.x     = {{(XY_W-ROOT_W){1'b0}}, sqrt_root};
    cell_head.y     = -(x_ext <<< Y_SHIFT);
    cell_head.z     = '0;
  end

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_in[g] = cell_head;
    end else begin : g_link
      assign cell_in[g] = cell_out[g-1];
    end

    atl_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shamt    (SHIFT_W'(g)),
      .atan     (ATAN_TAB[g]),
      .cell_in  (cell_in[g]),
      .cell_out (cell_out[g])
    );

    assign cell_v[g] = cell_out[g].valid;
  end

  atl_filter u_filt (
    .clk                (clk),
    .rst_n              (rst_n),
    .z_valid            (cell_out[LAST].valid),
    .z_in               (cell_out[LAST].z),
    .zero_vec           (zero_r),
    .angle_offset       (offset_r),
    .smoothing_gain     (gain_r),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_filtered_angle (out_filtered_angle),
    .stat               (filt_stat)
  );

  // only one transaction travels the cell chain
  a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_v))
    else $error("more than one transaction in cordic chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cell_v == '0) && filt_stat.idle)
    else $error("datapath active while not busy");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> busy_r && start_r)
    else $error("accepted transaction did not start square root");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    filt_stat.done |-> busy_r && !sqrt_done)
    else $error("filter finished without a transaction in flight");

endmodule
